>>> hw/rtl/dfsp_pkg.sv
package dfsp_pkg;

    // field widths of the request and response items
    localparam int REQ_W  = 2;
    localparam int VERT_W = 4;
    localparam int CNT_W  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // vertex count after reset
    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_ADD_WB,
        S_ROW_RD,
        S_SCAN,
        S_POP,
        S_WALK,
        S_WALK_LD,
        S_OUT
    } t_state;

endpackage

>>> hw/rtl/dfsp_req_if.sv
interface dfsp_req_if
    import dfsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;

    modport source (output valid, output req_type, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                    output ready);
endinterface

>>> hw/rtl/dfsp_rsp_if.sv
interface dfsp_rsp_if
    import dfsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [VERT_W-1:0] next_vertex;

    modport source (output valid, output found, output next_vertex, input ready);
    modport sink   (input valid, input found, input next_vertex, output ready);
endinterface

>>> hw/rtl/dfs_path_first_hop.sv
// steps: an add reads row a, writes row a while row b is read, then writes row b; a clear
//   empties the row valid bits; a query with start equal to target or out of range goes
//   straight to the output; a search scans rows and pops frames, then walks the discoverers
// throughput: one item at a time, ready only while idle; the one neighbor compare steps
//   one adjacency bit per cycle while scanning, held by each row read and stack pop
// reset: synchronous active low, per-row valid bits empty the graph at once, count 16
module dfs_path_first_hop
    import dfsp_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    dfsp_req_if.sink         i_req,
    dfsp_rsp_if.source       o_rsp
);
    localparam int VW = $clog2(MAX_VERTICES);       // vertex index width
    localparam int UW = $clog2(MAX_VERTICES + 1);   // scan position / count width
    localparam int SW = VW + UW;                    // stack frame: vertex and scan position
    localparam logic [MAX_VERTICES-1:0] BIT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    // sequencer and control
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_num_vert;
    logic [MAX_VERTICES-1:0] r_row_vld, n_row_vld;   // row not valid reads as empty
    logic                    r_out_valid, n_out_valid;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;

    // search datapath
    logic [VW-1:0]           r_v, n_v;               // vertex on top of the stack
    logic [UW-1:0]           r_u, n_u;               // its scan position
    logic [VW-1:0]           r_depth, n_depth;       // frames held in the stack memory
    logic [VW-1:0]           r_a, n_a;
    logic [VW-1:0]           r_b, n_b;
    logic [VW-1:0]           r_i, n_i;               // discoverer chain walk
    logic [VW-1:0]           r_j, n_j;
    logic [UW-1:0]           r_steps, n_steps;
    logic                    r_found, n_found;
    logic [VERT_W-1:0]       r_next, n_next;
    logic                    r_out_found, n_out_found;
    logic [VERT_W-1:0]       r_out_next, n_out_next;
    logic                    r_rvld;

    // memory ports
    logic                    adj_we;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata, row_q;
    logic                    disc_we;
    logic [VW-1:0]           disc_waddr, disc_raddr;
    logic [VW-1:0]           disc_wdata, disc_rdata;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr, stk_raddr;
    logic [SW-1:0]           stk_wdata, stk_rdata;

    logic [UW-1:0]           n_eff;
    logic                    req_xfer;
    logic                    a_ok, b_ok;
    logic [VW-1:0]           u_idx;
    logic                    can_push;

    // adjacency rows, discoverer of each vertex, and the search stack
    dfsp_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    dfsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_disc (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (disc_wdata),
        .i_raddr (disc_raddr),
        .o_rdata (disc_rdata)
    );

    dfsp_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // count saturates at the vertex capacity
    assign n_eff = (32'(r_num_vert) > 32'(MAX_VERTICES)) ? UW'(MAX_VERTICES)
                                                          : UW'(r_num_vert);

    assign i_req.ready       = (r_state == S_IDLE);
    assign req_xfer          = i_req.valid && i_req.ready;
    assign a_ok              = 32'(i_req.vertex_a) < 32'(n_eff);
    assign b_ok              = 32'(i_req.vertex_b) < 32'(n_eff);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.next_vertex = r_out_next;

    assign row_q    = r_rvld ? adj_rdata : '0;
    assign u_idx    = VW'(r_u);
    assign can_push = 32'(r_depth) < 32'(MAX_VERTICES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_vert  <= CNT_RESET;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
            r_visited   <= '0;
        end else begin
            r_state     <= n_state;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
            r_visited   <= n_visited;
            if (i_cfg_we) begin
                r_num_vert <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_u         <= n_u;
        r_depth     <= n_depth;
        r_a         <= n_a;
        r_b         <= n_b;
        r_i         <= n_i;
        r_j         <= n_j;
        r_steps     <= n_steps;
        r_found     <= n_found;
        r_next      <= n_next;
        r_out_found <= n_out_found;
        r_out_next  <= n_out_next;
        r_rvld      <= r_row_vld[adj_raddr];    // follows the registered row read
    end

    always_comb begin
        n_state     = r_state;
        n_row_vld   = r_row_vld;
        n_out_valid = r_out_valid;
        n_visited   = r_visited;
        n_v         = r_v;
        n_u         = r_u;
        n_depth     = r_depth;
        n_a         = r_a;
        n_b         = r_b;
        n_i         = r_i;
        n_j         = r_j;
        n_steps     = r_steps;
        n_found     = r_found;
        n_next      = r_next;
        n_out_found = r_out_found;
        n_out_next  = r_out_next;

        adj_we      = 1'b0;
        adj_waddr   = r_a;
        adj_wdata   = row_q | (BIT0 << r_b);
        adj_raddr   = r_v;
        disc_we     = 1'b0;
        disc_waddr  = u_idx;
        disc_wdata  = r_v;
        disc_raddr  = r_i;
        stk_we      = 1'b0;
        stk_waddr   = r_depth;
        stk_wdata   = {r_v, r_u + UW'(1)};
        stk_raddr   = r_depth - VW'(1);

        // response transfer frees the output register
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_a = VW'(i_req.vertex_a);
                    n_b = VW'(i_req.vertex_b);
                    case (i_req.req_type)
                        REQ_ADD: begin
                            // edges with an endpoint out of range are dropped
                            if (a_ok && b_ok) begin
                                n_state = S_ADD_A;
                            end
                        end
                        REQ_CLEAR: begin
                            n_row_vld = '0;
                        end
                        REQ_QUERY: begin
                            if (i_req.vertex_a == i_req.vertex_b) begin
                                n_found = 1'b1;
                                n_next  = i_req.vertex_a;
                                n_state = S_OUT;
                            end else if (!a_ok || !b_ok) begin
                                n_found = 1'b0;
                                n_next  = '0;
                                n_state = S_OUT;
                            end else begin
                                n_visited = BIT0 << VW'(i_req.vertex_a);
                                n_v       = VW'(i_req.vertex_a);
                                n_u       = '0;
                                n_depth   = '0;
                                n_state   = S_ROW_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_A: begin
                adj_raddr = r_a;
                n_state   = S_ADD_B;
            end
            S_ADD_B: begin
                // write row a while row b is read
                adj_raddr      = r_b;
                adj_we         = 1'b1;
                adj_waddr      = r_a;
                adj_wdata      = row_q | (BIT0 << r_b);
                n_row_vld[r_a] = 1'b1;
                n_state        = S_ADD_WB;
            end
            S_ADD_WB: begin
                adj_we         = 1'b1;
                adj_waddr      = r_b;
                adj_wdata      = row_q | (BIT0 << r_a);
                n_row_vld[r_b] = 1'b1;
                n_state        = S_IDLE;
            end
            S_ROW_RD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_u >= n_eff) begin
                    if (r_depth == '0) begin
                        if (r_visited[r_b]) begin
                            n_i     = r_b;
                            n_j     = r_b;
                            n_steps = '0;
                            n_state = S_WALK;
                        end else begin
                            n_found = 1'b0;
                            n_next  = '0;
                            n_state = S_OUT;
                        end
                    end else begin
                        // stack read issued here, frame loads next cycle
                        n_state = S_POP;
                    end
                end else begin
                    n_u = r_u + UW'(1);
                    if (row_q[u_idx] && !r_visited[u_idx]) begin
                        n_visited[u_idx] = 1'b1;
                        disc_we          = 1'b1;
                        if (can_push) begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + VW'(1);
                            n_v     = u_idx;
                            n_u     = '0;
                            n_state = S_ROW_RD;
                        end
                    end
                end
            end
            S_POP: begin
                n_v     = stk_rdata[SW-1:UW];
                n_u     = stk_rdata[UW-1:0];
                n_depth = r_depth - VW'(1);
                n_state = S_ROW_RD;
            end
            S_WALK: begin
                // discoverer read of r_i issued here
                if (r_i == r_a || r_steps >= n_eff) begin
                    n_found = 1'b1;
                    n_next  = VERT_W'(r_j);
                    n_state = S_OUT;
                end else begin
                    n_state = S_WALK_LD;
                end
            end
            S_WALK_LD: begin
                n_j     = r_i;
                n_i     = disc_rdata;
                n_steps = r_steps + UW'(1);
                n_state = S_WALK;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_next  = r_next;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && i_req.req_type == REQ_QUERY) |=> !i_req.ready)
        else $error("ready high right after a query transfer");

    // the start vertex stays marked through the whole search
    a_start_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_visited[r_a])
        else $error("start vertex not marked visited during scan");

    // every stacked frame belongs to a distinct visited vertex
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'($countones(r_visited)) > 32'(r_depth)))
        else $error("stack deeper than the visited set");

    // the path walk only visits vertices reached by this search
    a_walk_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> r_visited[r_i])
        else $error("path walk left the search tree");

    // a result is never dropped while the output register is full
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> r_out_valid)
        else $error("pending response lost");
endmodule

>>> hw/rtl/dfsp_ram.sv
module dfsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
